/* design/gsg_pkg.sv */
// shared types and constants of the greedy slot grant scheduler
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package gsg_pkg;

  // table geometry
  localparam int unsigned MaxTerminals = 16;
  localparam int unsigned IdxW         = $clog2(MaxTerminals);
  localparam int unsigned CntW         = $clog2(MaxTerminals + 1);

  // field widths
  localparam int unsigned IdW    = 4;
  localparam int unsigned DemW   = 8;
  localparam int unsigned ByteW  = 16;
  localparam int unsigned TotalW = 32;
  localparam int unsigned TcW    = 5;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSlotCapacity  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTerminalCount = 2'd1;

  // register reset values
  localparam logic [DemW-1:0] SlotCapReset   = 8'd64;
  localparam logic [TcW-1:0]  TermCountReset = 5'd16;

  // item kinds
  localparam logic KindRequest = 1'b0;
  localparam logic KindBytes   = 1'b1;

  // one input item
  typedef struct packed {
    logic             kind;
    logic [IdW-1:0]   terminal_id;
    logic             active;
    logic [DemW-1:0]  demand;
    logic [ByteW-1:0] byte_count;
  } req_t;

  // one stored request
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [DemW-1:0] dem;
  } entry_t;

  // work handed from intake to the sorter on a slot request
  typedef struct packed {
    logic              go;
    logic              flush;
    logic [TotalW-1:0] bytes;
    logic [CntW-1:0]   cnt;
    logic [DemW-1:0]   capacity;
  } job_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_SCAN,
    ST_GRANT
  } state_e;

endpackage

`default_nettype wire

/* design/gsg_if.sv */
// item channels and configuration write channel of the scheduler
// depends on gsg_pkg for field widths
`default_nettype none

interface gsg_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [gsg_pkg::IdW-1:0]   terminal_id;
  logic                      active;
  logic [gsg_pkg::DemW-1:0]  demand;
  logic [gsg_pkg::ByteW-1:0] byte_count;

  modport source (output valid, kind, terminal_id, active, demand, byte_count,
                  input ready);
  modport sink (input valid, kind, terminal_id, active, demand, byte_count,
                output ready);
endinterface

interface gsg_res_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [gsg_pkg::IdW-1:0]    grant_terminal;
  logic [gsg_pkg::DemW-1:0]   grant_demand;
  logic                       granted;
  logic [gsg_pkg::TotalW-1:0] byte_total;
  logic                       last;

  modport source (output valid, result_kind, grant_terminal, grant_demand, granted,
                  byte_total, last, input ready);
  modport sink (input valid, result_kind, grant_terminal, grant_demand, granted,
                byte_total, last, output ready);
endinterface

interface gsg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gsg_pkg::CfgIdxW-1:0]  index;
  logic [gsg_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/greedy_slot_grant_scheduler.sv */
// Greedy slot grant scheduler. A byte report adds to a saturating 32-bit
// total. A slot request first flushes a nonzero byte total as a byte result.
// The request that closes a round with stored requests keeps the input
// blocked until every grant has been decided and loaded into the result
// register, also while the result side stalls: one comparator walks the stored
// requests once per grant to find the largest remaining demand, then decides
// that grant against the capacity left. Results leave through a register, so
// the final result may still wait while the next item is taken. Ties in demand
// are granted in arrival order.
// depends on gsg_pkg, gsg_if, gsg_intake, gsg_sorter
`default_nettype none

module greedy_slot_grant_scheduler (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  gsg_req_if.sink   req_i,
  gsg_res_if.source res_o,
  gsg_cfg_if.sink   cfg_i
);

  gsg_pkg::req_t               req;
  gsg_pkg::job_t               job;
  gsg_pkg::entry_t             rd_entry;
  logic [gsg_pkg::IdxW-1:0]    rd_idx;
  logic [gsg_pkg::DemW-1:0]    capacity;
  logic                        idle;
  logic                        req_fire;
  logic                        cfg_fire;

  // handshakes
  assign req_i.ready = idle;
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // pack the input item
  always_comb begin
    req.kind        = req_i.kind;
    req.terminal_id = req_i.terminal_id;
    req.active      = req_i.active;
    req.demand      = req_i.demand;
    req.byte_count  = req_i.byte_count;
  end

  gsg_intake u_intake (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_fire_i  (req_fire),
    .req_i       (req),
    .cfg_fire_i  (cfg_fire),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .rd_idx_i    (rd_idx),
    .rd_entry_o  (rd_entry),
    .job_o       (job),
    .capacity_o  (capacity)
  );

  gsg_sorter u_sorter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job),
    .rd_idx_o       (rd_idx),
    .rd_entry_i     (rd_entry),
    .idle_o         (idle),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .res_kind_o     (res_o.result_kind),
    .res_terminal_o (res_o.grant_terminal),
    .res_demand_o   (res_o.grant_demand),
    .res_granted_o  (res_o.granted),
    .res_total_o    (res_o.byte_total),
    .res_last_o     (res_o.last)
  );

  // a flushing request must hold off the next item
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.go && job.flush |=> !req_i.ready)
    else $error("input taken while a byte result is pending");

  // a byte result never carries an empty total
  a_bytes_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.result_kind == gsg_pkg::KindBytes) |-> res_o.byte_total != '0)
    else $error("byte result with zero total");

  // a granted demand always fits within the frame capacity
  a_grant_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.result_kind == gsg_pkg::KindRequest) && res_o.granted
    |-> res_o.grant_demand <= capacity)
    else $error("grant exceeds slot capacity");

endmodule

`default_nettype wire

/* design/gsg_intake.sv */
// intake: configuration registers, byte accumulator, round counters, request table
// depends on gsg_pkg
`default_nettype none

module gsg_intake (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_fire_i,
  input  wire gsg_pkg::req_t                req_i,
  input  wire logic                         cfg_fire_i,
  input  wire logic [gsg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [gsg_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [gsg_pkg::IdxW-1:0]     rd_idx_i,
  output gsg_pkg::entry_t                   rd_entry_o,
  output gsg_pkg::job_t                     job_o,
  output logic [gsg_pkg::DemW-1:0]          capacity_o
);

  logic [gsg_pkg::DemW-1:0]   slot_capacity_q, slot_capacity_d;
  logic [gsg_pkg::TcW-1:0]    terminal_count_q, terminal_count_d;
  logic [gsg_pkg::TcW-1:0]    reports_left_q, reports_left_d;
  logic [gsg_pkg::CntW-1:0]   stored_count_q, stored_count_d;
  logic [gsg_pkg::TotalW-1:0] acc_q, acc_d;

  gsg_pkg::entry_t table_q [gsg_pkg::MaxTerminals];

  logic                       bytes_fire;
  logic                       slot_fire;
  logic                       do_store;
  logic                       round_end;
  logic [gsg_pkg::CntW-1:0]   new_cnt;
  logic [gsg_pkg::TotalW:0]   acc_sum;

  assign bytes_fire = req_fire_i && (req_i.kind == gsg_pkg::KindBytes);
  assign slot_fire  = req_fire_i && (req_i.kind == gsg_pkg::KindRequest);
  assign do_store   = slot_fire && req_i.active &&
                      (stored_count_q < gsg_pkg::CntW'(gsg_pkg::MaxTerminals));
  assign new_cnt    = stored_count_q + gsg_pkg::CntW'(do_store);
  // a count of zero behaves like one
  assign round_end  = reports_left_q <= gsg_pkg::TcW'(1);
  assign acc_sum    = {1'b0, acc_q} + {{(gsg_pkg::TotalW + 1 - gsg_pkg::ByteW){1'b0}},
                                       req_i.byte_count};

  // job for the sorter, valid in the cycle of the slot request
  always_comb begin
    job_o.go       = slot_fire;
    job_o.flush    = acc_q != '0;
    job_o.bytes    = acc_q;
    job_o.cnt      = round_end ? new_cnt : '0;
    job_o.capacity = slot_capacity_q;
  end

  // next values of counters, accumulator and registers
  always_comb begin
    slot_capacity_d  = slot_capacity_q;
    terminal_count_d = terminal_count_q;
    reports_left_d   = reports_left_q;
    stored_count_d   = stored_count_q;
    acc_d            = acc_q;
    if (bytes_fire) begin
      // saturating accumulate
      acc_d = acc_sum[gsg_pkg::TotalW] ? '1 : acc_sum[gsg_pkg::TotalW-1:0];
    end
    if (slot_fire) begin
      acc_d = '0;
      if (round_end) begin
        stored_count_d = '0;
        reports_left_d = terminal_count_q;
      end else begin
        stored_count_d = new_cnt;
        reports_left_d = reports_left_q - gsg_pkg::TcW'(1);
      end
    end
    if (cfg_fire_i) begin
      case (cfg_index_i)
        gsg_pkg::CfgSlotCapacity: begin
          slot_capacity_d = cfg_data_i[gsg_pkg::DemW-1:0];
        end
        gsg_pkg::CfgTerminalCount: begin
          terminal_count_d = cfg_data_i[gsg_pkg::TcW-1:0];
          reports_left_d   = cfg_data_i[gsg_pkg::TcW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_capacity_q  <= gsg_pkg::SlotCapReset;
      terminal_count_q <= gsg_pkg::TermCountReset;
      reports_left_q   <= gsg_pkg::TermCountReset;
      stored_count_q   <= '0;
      acc_q            <= '0;
    end else begin
      slot_capacity_q  <= slot_capacity_d;
      terminal_count_q <= terminal_count_d;
      reports_left_q   <= reports_left_d;
      stored_count_q   <= stored_count_d;
      acc_q            <= acc_d;
    end
  end

  // request table, filled in arrival order
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      table_q[stored_count_q[gsg_pkg::IdxW-1:0]] <= '{id: req_i.terminal_id,
                                                      dem: req_i.demand};
    end
  end

  assign rd_entry_o = table_q[rd_idx_i];
  assign capacity_o = slot_capacity_q;

endmodule

`default_nettype wire

/* design/gsg_sorter.sv */
// sorter: sequencer around one shared comparator that picks the largest
// remaining demand per pass and decides each grant; holds the result register
// depends on gsg_pkg
`default_nettype none

module gsg_sorter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gsg_pkg::job_t              job_i,
  output logic [gsg_pkg::IdxW-1:0]        rd_idx_o,
  input  wire gsg_pkg::entry_t            rd_entry_i,
  output logic                            idle_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output logic                            res_kind_o,
  output logic [gsg_pkg::IdW-1:0]         res_terminal_o,
  output logic [gsg_pkg::DemW-1:0]        res_demand_o,
  output logic                            res_granted_o,
  output logic [gsg_pkg::TotalW-1:0]      res_total_o,
  output logic                            res_last_o
);

  gsg_pkg::state_e state_q, state_d;

  logic [gsg_pkg::TotalW-1:0]       bytes_q;
  logic [gsg_pkg::CntW-1:0]         cnt_q;
  logic [gsg_pkg::DemW-1:0]         remaining_q;
  logic [gsg_pkg::IdxW-1:0]         idx_q;
  logic                             found_q;
  logic [gsg_pkg::DemW-1:0]         best_dem_q;
  logic [gsg_pkg::IdW-1:0]          best_id_q;
  logic [gsg_pkg::IdxW-1:0]         best_idx_q;
  logic [gsg_pkg::MaxTerminals-1:0] done_q;
  logic [gsg_pkg::CntW-1:0]         emitted_q;

  logic                             out_free;
  logic                             scan_end;
  logic                             grant_last;
  logic [gsg_pkg::CntW-1:0]         emitted_nxt;
  logic                             load_bytes;
  logic                             load_grant;
  logic                             scan_step;
  logic                             take;

  // shared comparator
  logic [gsg_pkg::DemW-1:0]         cmp_a, cmp_b;
  logic                             cmp_gt;

  assign out_free    = !res_valid_o || res_ready_i;
  assign scan_end    = {1'b0, idx_q} == (cnt_q - gsg_pkg::CntW'(1));
  assign emitted_nxt = emitted_q + gsg_pkg::CntW'(1);
  assign grant_last  = emitted_nxt == cnt_q;
  assign rd_idx_o    = idx_q;

  // in a scan the comparator ranks the entry against the best so far,
  // in a grant it checks the best demand against the remaining capacity
  always_comb begin
    if (state_q == gsg_pkg::ST_GRANT) begin
      cmp_a = best_dem_q;
      cmp_b = remaining_q;
    end else begin
      cmp_a = rd_entry_i.dem;
      cmp_b = best_dem_q;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  // strict compare keeps the earliest arrival among equal demands
  assign take = !done_q[idx_q] && (!found_q || cmp_gt);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gsg_pkg::ST_IDLE: begin
        if (job_i.go) begin
          if (job_i.flush) begin
            state_d = gsg_pkg::ST_FLUSH;
          end else if (job_i.cnt != '0) begin
            state_d = gsg_pkg::ST_SCAN;
          end
        end
      end
      gsg_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_d = (cnt_q != '0) ? gsg_pkg::ST_SCAN : gsg_pkg::ST_IDLE;
        end
      end
      gsg_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = gsg_pkg::ST_GRANT;
        end
      end
      gsg_pkg::ST_GRANT: begin
        if (out_free) begin
          state_d = grant_last ? gsg_pkg::ST_IDLE : gsg_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = gsg_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    load_bytes = 1'b0;
    load_grant = 1'b0;
    scan_step  = 1'b0;
    idle_o     = 1'b0;
    case (state_q)
      gsg_pkg::ST_IDLE:  idle_o     = 1'b1;
      gsg_pkg::ST_FLUSH: load_bytes = out_free;
      gsg_pkg::ST_SCAN:  scan_step  = 1'b1;
      gsg_pkg::ST_GRANT: load_grant = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // job context and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      found_q   <= 1'b0;
      done_q    <= '0;
      emitted_q <= '0;
    end else begin
      if (idle_o && job_i.go) begin
        idx_q     <= '0;
        found_q   <= 1'b0;
        done_q    <= '0;
        emitted_q <= '0;
      end
      if (scan_step) begin
        idx_q <= idx_q + gsg_pkg::IdxW'(1);
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (load_grant) begin
        idx_q              <= '0;
        found_q            <= 1'b0;
        done_q[best_idx_q] <= 1'b1;
        emitted_q          <= emitted_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (idle_o && job_i.go) begin
      bytes_q     <= job_i.bytes;
      cnt_q       <= job_i.cnt;
      remaining_q <= job_i.capacity;
    end
    if (scan_step && take) begin
      best_dem_q <= rd_entry_i.dem;
      best_id_q  <= rd_entry_i.id;
      best_idx_q <= idx_q;
    end
    if (load_grant && !cmp_gt) begin
      remaining_q <= remaining_q - best_dem_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else if (load_bytes || load_grant) begin
      res_valid_o <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_bytes) begin
      res_kind_o     <= gsg_pkg::KindBytes;
      res_terminal_o <= '0;
      res_demand_o   <= '0;
      res_granted_o  <= 1'b0;
      res_total_o    <= bytes_q;
      res_last_o     <= cnt_q == '0;
    end else if (load_grant) begin
      res_kind_o     <= gsg_pkg::KindRequest;
      res_terminal_o <= best_id_q;
      res_demand_o   <= best_dem_q;
      res_granted_o  <= !cmp_gt;
      res_total_o    <= '0;
      res_last_o     <= grant_last;
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench of greedy_slot_grant_scheduler: random and directed
// item streams, an in-bench grant predictor and a per-field result check
// depends on gsg_pkg, gsg_if and the scheduler rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsg_pkg::*;

  localparam int unsigned LongHold     = 300;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned NumPhases    = 8;

  // result kinds on the output channel
  localparam logic ResGrant = 1'b0;
  localparam logic ResBytes = 1'b1;

  // per-phase register plans, phase 0 in the low byte
  localparam logic [8*CfgDataW-1:0] CapPlan =
    {8'd64, 8'd200, 8'd37, 8'd255, 8'd1, 8'd100, 8'd255, 8'd0};
  localparam logic [8*CfgDataW-1:0] TcPlan =
    {8'd16, 8'd3, 8'd31, 8'd16, 8'd0, 8'd4, 8'd1, 8'd31};

  // one expected scheduler result
  typedef struct packed {
    logic              kind;
    logic [IdW-1:0]    term;
    logic [DemW-1:0]   dem;
    logic              granted;
    logic [TotalW-1:0] total;
    logic              last;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n;

  gsg_req_if req_if ();
  gsg_res_if res_if ();
  gsg_cfg_if cfg_if ();

  greedy_slot_grant_scheduler dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [DemW-1:0]   slot_cap;
  logic [TcW-1:0]    term_count;
  logic [TcW-1:0]    reqs_left;
  entry_t            req_tbl [MaxTerminals];
  int unsigned       n_stored;
  logic [TotalW-1:0] byte_acc;

  // grants and byte totals still owed by the block, items still to send
  sched_res_t  owed_q [$];
  req_t        send_q [$];

  int unsigned n_sent;
  int unsigned n_taken;
  int unsigned errors;
  bit          idle_en;
  int unsigned stall_asks;
  int unsigned stall_served;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  logic        in_fire;

  // register write as seen by the predictor
  task automatic sched_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    if (idx == CfgSlotCapacity) begin
      slot_cap = val;
    end else if (idx == CfgTerminalCount) begin
      term_count = val[TcW-1:0];
      reqs_left  = val[TcW-1:0];
    end
  endtask

  // one accepted item: update the predictor and queue the results it causes
  task automatic sched_step(input req_t r);
    entry_t      srt [MaxTerminals];
    entry_t      e;
    sched_res_t  res;
    int unsigned i;
    int unsigned j;
    int unsigned room;
    int unsigned added;
    added = 0;
    // byte report: saturating accumulate, no result
    if (r.kind == KindBytes) begin
      if (TotalW'(r.byte_count) > ~byte_acc) byte_acc = '1;
      else byte_acc = byte_acc + TotalW'(r.byte_count);
      return;
    end
    // flush the byte total ahead of the request
    if (byte_acc != '0) begin
      res       = '0;
      res.kind  = ResBytes;
      res.total = byte_acc;
      owed_q.push_back(res);
      added++;
      byte_acc = '0;
    end
    // store active requests while there is room
    if (r.active && n_stored < MaxTerminals) begin
      req_tbl[n_stored].id  = r.terminal_id;
      req_tbl[n_stored].dem = r.demand;
      n_stored++;
    end
    if (reqs_left <= 1) begin
      // stable sort by descending demand
      for (i = 0; i < n_stored; i++) begin
        e = req_tbl[i];
        j = i;
        while (j > 0 && srt[j-1].dem < e.dem) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = e;
      end
      // grant greedily against the capacity left
      room = slot_cap;
      for (i = 0; i < n_stored; i++) begin
        res      = '0;
        res.kind = ResGrant;
        res.term = srt[i].id;
        res.dem  = srt[i].dem;
        if (srt[i].dem <= room) begin
          room        = room - srt[i].dem;
          res.granted = 1'b1;
        end
        owed_q.push_back(res);
        added++;
      end
      n_stored  = 0;
      reqs_left = term_count;
    end else begin
      reqs_left = reqs_left - 1'b1;
    end
    if (added > 0) owed_q[owed_q.size()-1].last = 1'b1;
  endtask

  function automatic req_t mk_req(input logic kind, input int id, input logic act,
                                  input int dem, input int bytes);
    req_t r;
    r.kind        = kind;
    r.terminal_id = id[IdW-1:0];
    r.active      = act;
    r.demand      = dem[DemW-1:0];
    r.byte_count  = bytes[ByteW-1:0];
    // fields the item kind ignores carry noise
    if (kind == KindBytes) begin
      r.terminal_id = $urandom_range(0, 15);
      r.active      = $urandom_range(0, 1);
      r.demand      = $urandom_range(0, 255);
    end else begin
      r.byte_count = $urandom_range(0, 65535);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [TotalW-1:0] want,
                                      input logic [TotalW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic offer(input req_t r);
    send_q.push_back(r);
    n_sent++;
  endtask

  // wait until every item is taken and every result has come, then let the block settle
  task automatic drain();
    while (!(n_taken == n_sent && owed_q.size() == 0)) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sched_write(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // input side: count accepted items and feed the predictor
  always @(posedge clk or negedge rst_n) begin : intake_watch
    req_t seen;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        seen.kind        = req_if.kind;
        seen.terminal_id = req_if.terminal_id;
        seen.active      = req_if.active;
        seen.demand      = req_if.demand;
        seen.byte_count  = req_if.byte_count;
        n_taken++;
        sched_step(seen);
      end
    end
  end

  // item driver with random idle bursts
  always @(negedge clk) begin : item_driver
    req_t nxt;
    if (rst_n && (!req_if.valid || in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        req_if.valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        nxt = send_q.pop_front();
        req_if.valid       <= 1'b1;
        req_if.kind        <= nxt.kind;
        req_if.terminal_id <= nxt.terminal_id;
        req_if.active      <= nxt.active;
        req_if.demand      <= nxt.demand;
        req_if.byte_count  <= nxt.byte_count;
        if (idle_en && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 4);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall bursts, plus long hold-offs on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_served != stall_asks) begin
        stall_served = stall_asks;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 4) == 0) rx_gap = $urandom_range(1, 4);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    sched_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: kind %0b term %0d demand %0d granted %0b total %0d",
                 $time, res_if.result_kind, res_if.grant_terminal, res_if.grant_demand,
                 res_if.granted, res_if.byte_total);
        errors++;
      end else begin
        want = owed_q.pop_front();
        check_field("result_kind", want.kind, res_if.result_kind);
        check_field("grant_terminal", want.term, res_if.grant_terminal);
        check_field("grant_demand", want.dem, res_if.grant_demand);
        check_field("granted", want.granted, res_if.granted);
        check_field("byte_total", want.total, res_if.byte_total);
        check_field("last", want.last, res_if.last);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus sequence
  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    int unsigned cnt;
    int          dem;
    int          bytes;
    logic [CfgDataW-1:0] cap;
    logic [CfgDataW-1:0] tc;

    // known values on every input from time zero
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = KindRequest;
    req_if.terminal_id = '0;
    req_if.active      = 1'b0;
    req_if.demand      = '0;
    req_if.byte_count  = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CfgSlotCapacity;
    cfg_if.data        = '0;

    slot_cap     = SlotCapReset;
    term_count   = TermCountReset;
    reqs_left    = TermCountReset;
    n_stored     = 0;
    byte_acc     = '0;
    n_sent       = 0;
    n_taken      = 0;
    errors       = 0;
    idle_en      = 1'b1;
    stall_asks   = 0;
    stall_served = 0;
    tx_gap       = 0;
    rx_gap       = 0;
    hold_left    = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset registers: field extremes, inactive request, demand ties, full round of 16
    offer(mk_req(KindBytes, 0, 1'b0, 0, 16'hFFFF));
    offer(mk_req(KindBytes, 0, 1'b0, 0, 16'h0000));
    offer(mk_req(KindRequest, 15, 1'b1, 255, 0));
    offer(mk_req(KindRequest, 0, 1'b1, 0, 0));
    offer(mk_req(KindRequest, 5, 1'b1, 64, 0));
    offer(mk_req(KindRequest, 3, 1'b0, 77, 0));
    offer(mk_req(KindRequest, 7, 1'b1, 10, 0));
    offer(mk_req(KindRequest, 8, 1'b1, 10, 0));
    offer(mk_req(KindBytes, 0, 1'b0, 0, 1));
    offer(mk_req(KindRequest, 9, 1'b1, 63, 0));
    offer(mk_req(KindRequest, 10, 1'b1, 1, 0));
    offer(mk_req(KindRequest, 2, 1'b1, 10, 0));
    offer(mk_req(KindRequest, 4, 1'b0, 0, 0));
    offer(mk_req(KindRequest, 6, 1'b1, 128, 0));
    offer(mk_req(KindRequest, 11, 1'b1, 200, 0));
    offer(mk_req(KindRequest, 12, 1'b1, 5, 0));
    offer(mk_req(KindRequest, 13, 1'b1, 64, 0));
    offer(mk_req(KindRequest, 14, 1'b1, 255, 0));
    offer(mk_req(KindRequest, 0, 1'b1, 1, 0));
    drain();

    // terminal count zero closes a round on every request
    write_reg(CfgSlotCapacity, 8'd255);
    write_reg(CfgTerminalCount, 8'd0);
    offer(mk_req(KindRequest, 1, 1'b1, 200, 0));
    offer(mk_req(KindRequest, 2, 1'b0, 0, 0));
    offer(mk_req(KindBytes, 0, 1'b0, 0, 1));
    offer(mk_req(KindRequest, 3, 1'b1, 255, 0));
    drain();

    // random phases, each under its own register setting
    for (p = 0; p < NumPhases; p++) begin
      cap = CapPlan[p*CfgDataW +: CfgDataW];
      tc  = TcPlan[p*CfgDataW +: CfgDataW];
      if (p == 5 || p == 7) cap = $urandom_range(0, 255);
      if (p == 6) tc = $urandom_range(1, 31);
      write_reg(CfgSlotCapacity, cap);
      write_reg(CfgTerminalCount, tc);
      if (p == 2) stall_asks++;
      if (p == NumPhases - 1) idle_en = 1'b0;
      cnt = $urandom_range(45, 65);
      for (k = 0; k < cnt; k++) begin
        case ($urandom_range(0, 3))
          0:       dem = $urandom_range(0, 15);
          1:       dem = $urandom_range(0, 1) ? 255 : 0;
          default: dem = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 3))
          0:       bytes = 0;
          1:       bytes = 16'hFFFF;
          default: bytes = $urandom_range(0, 65535);
        endcase
        offer(mk_req($urandom_range(0, 3) == 0 ? KindBytes : KindRequest,
                     $urandom_range(0, 15), $urandom_range(0, 7) != 0, dem, bytes));
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
